@@ rtl/core/hhcf_pkg.sv @@
package hhcf_pkg;

    localparam int AGENT_LEN  = 10;
    localparam int ACCEPT_LEN = 6;

    // "User-Agent" and "Accept", first character at index 0
    localparam logic [7:0] AGENT_PAT [AGENT_LEN] = '{
        8'h55, 8'h73, 8'h65, 8'h72, 8'h2d, 8'h41, 8'h67, 8'h65, 8'h6e, 8'h74
    };
    localparam logic [7:0] ACCEPT_PAT [ACCEPT_LEN] = '{
        8'h41, 8'h63, 8'h63, 8'h65, 8'h70, 8'h74
    };

    localparam int COUNT_BITS = 4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [2:0] VERDICT_CAPTURED  = 3'd0;
    localparam logic [2:0] VERDICT_NOT_TCP   = 3'd1;
    localparam logic [2:0] VERDICT_QUOTA     = 3'd2;
    localparam logic [2:0] VERDICT_NO_AGENT  = 3'd3;
    localparam logic [2:0] VERDICT_TOO_CLOSE = 3'd4;
    localparam logic [2:0] VERDICT_NO_ACCEPT = 3'd5;

    localparam logic CFG_HOST_QUOTA = 1'b0;
    localparam logic CFG_MIN_GAP    = 1'b1;

    localparam logic [3:0]  QUOTA_RESET   = 4'd3;
    localparam logic [15:0] MIN_GAP_RESET = 16'd128;

    // result beat, capture in the lowest bit
    typedef struct packed {
        logic [15:0]           packet_length;
        logic [COUNT_BITS-1:0] host_count;
        logic [2:0]            verdict;
        logic                  capture;
    } result_t;

endpackage

@@ rtl/core/hhcf_ram.sv @@
module hhcf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/http_header_capture_filter.sv @@
// Output: the last byte of a packet passes the input register, then the match stage loads the
// registered result beat, which holds while m_tready is low.
// One byte per cycle unless a last byte waits on a held result beat; the host counter read is
// issued at acceptance and its registered data is ready when the byte reaches the match stage.
// Reset (aresetn low, synchronous): all host counters read as zero through per-host
// valid bits, packet state clears, host_quota returns to 3 and min_gap to 128.
module http_header_capture_filter
    import hhcf_pkg::*;
#(
    parameter int HOST_ENTRIES  = 256,
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], host_octet[15:8]
    input  logic [1:0]  s_tuser,   // first_byte[0], is_tcp[1]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // capture[0], verdict[3:1], host_count[7:4],
                                   // packet_length[23:8]
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wr_data
);

    localparam int AW = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
    localparam logic [PB-1:0] AGENT_BACK = PB'(AGENT_LEN - 1);

    // host octet to table index
    logic [AW-1:0] host_map [256];
    for (genvar g = 0; g < 256; g++) begin : g_host_map
        assign host_map[g] = AW'(g % HOST_ENTRIES);
    end

    logic [3:0]  quota_reg;
    logic [15:0] min_gap_reg;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic [AW-1:0] in_host_reg;
    logic          in_first_reg;
    logic          in_last_reg;
    logic          in_tcp_reg;

    logic                  rd_valid_reg;
    logic                  rd_hit_reg;
    logic [COUNT_BITS-1:0] rd_hit_data_reg;
    logic [HOST_ENTRIES-1:0] count_valid_reg;

    logic [7:0]            hist_reg [AGENT_LEN];
    logic [PB-1:0]         pos_reg;
    logic                  agent_seen_reg;
    logic [PB-1:0]         agent_start_reg;
    logic                  decided_reg;
    logic [2:0]            verdict_reg;
    logic [AW-1:0]         host_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic    out_valid_reg;
    result_t out_data_reg;

    logic                  s_accept;
    logic                  advance;
    logic [AW-1:0]         rd_addr;
    logic [COUNT_BITS-1:0] ram_rd_data;
    logic                  wr_en;

    logic [7:0]            hist_next [AGENT_LEN];
    logic [PB-1:0]         pos_next;
    logic                  agent_seen_next;
    logic [PB-1:0]         agent_start_next;
    logic                  decided_next;
    logic [2:0]            verdict_next;
    logic [AW-1:0]         host_next;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_new;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign rd_addr  = host_map[s_tdata[15:8]];
    assign wr_en    = advance && in_last_reg && (verdict_next == VERDICT_CAPTURED);

    hhcf_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(HOST_ENTRIES)
    ) u_count_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(host_next),
        .wr_data(count_new),
        .rd_en  (s_accept),
        .rd_addr(rd_addr),
        .rd_data(ram_rd_data)
    );

    always_comb begin
        logic                  start;
        logic [COUNT_BITS-1:0] lookup;
        logic [PB-1:0]         idx;
        logic                  agent_hit;
        logic                  accept_hit;

        start = in_first_reg || (pos_reg == '0);
        if (rd_hit_reg) begin
            lookup = rd_hit_data_reg;
        end else if (rd_valid_reg) begin
            lookup = ram_rd_data;
        end else begin
            lookup = '0;
        end

        if (start) begin
            idx              = '0;
            agent_seen_next  = 1'b0;
            agent_start_next = '0;
            host_next        = in_host_reg;
            count_next       = lookup;
            if (!in_tcp_reg) begin
                decided_next = 1'b1;
                verdict_next = VERDICT_NOT_TCP;
            end else if (lookup >= quota_reg) begin
                decided_next = 1'b1;
                verdict_next = VERDICT_QUOTA;
            end else begin
                decided_next = 1'b0;
                verdict_next = VERDICT_NO_AGENT;
            end
        end else begin
            idx              = pos_reg;
            agent_seen_next  = agent_seen_reg;
            agent_start_next = agent_start_reg;
            host_next        = host_reg;
            count_next       = count_reg;
            decided_next     = decided_reg;
            verdict_next     = verdict_reg;
        end

        hist_next[0] = in_byte_reg;
        for (int k = 1; k < AGENT_LEN; k++) begin
            hist_next[k] = start ? 8'h00 : hist_reg[k-1];
        end

        agent_hit = 1'b1;
        for (int m = 0; m < AGENT_LEN; m++) begin
            if (hist_next[AGENT_LEN-1-m] != AGENT_PAT[m]) begin
                agent_hit = 1'b0;
            end
        end
        accept_hit = 1'b1;
        for (int m = 0; m < ACCEPT_LEN; m++) begin
            if (hist_next[ACCEPT_LEN-1-m] != ACCEPT_PAT[m]) begin
                accept_hit = 1'b0;
            end
        end

        pos_next = (idx != POS_MAX) ? idx + 1'b1 : idx;

        if (!decided_next) begin
            if (!agent_seen_next) begin
                if (agent_hit) begin
                    agent_seen_next  = 1'b1;
                    agent_start_next = (idx >= AGENT_BACK) ? idx - AGENT_BACK : '0;
                    verdict_next     = VERDICT_NO_ACCEPT;
                end
            end else if (accept_hit) begin
                decided_next = 1'b1;
                verdict_next = (16'(idx - agent_start_next) > min_gap_reg) ?
                               VERDICT_CAPTURED : VERDICT_TOO_CLOSE;
            end
        end

        if (verdict_next == VERDICT_CAPTURED && count_next != COUNT_MAX) begin
            count_new = count_next + 1'b1;
        end else begin
            count_new = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quota_reg   <= QUOTA_RESET;
            min_gap_reg <= MIN_GAP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HOST_QUOTA: quota_reg   <= cfg_wr_data[3:0];
                CFG_MIN_GAP:    min_gap_reg <= cfg_wr_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // byte payload and counter lookup; a write to the same host in this cycle is bypassed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg     <= s_tdata[7:0];
            in_host_reg     <= rd_addr;
            in_first_reg    <= s_tuser[0];
            in_tcp_reg      <= s_tuser[1];
            in_last_reg     <= s_tlast;
            rd_valid_reg    <= count_valid_reg[rd_addr];
            rd_hit_reg      <= wr_en && (host_next == rd_addr);
            rd_hit_data_reg <= count_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_valid_reg <= '0;
        end else if (wr_en) begin
            count_valid_reg[host_next] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < AGENT_LEN; k++) begin
                hist_reg[k] <= 8'h00;
            end
            pos_reg         <= '0;
            agent_seen_reg  <= 1'b0;
            agent_start_reg <= '0;
            decided_reg     <= 1'b0;
            verdict_reg     <= VERDICT_CAPTURED;
            host_reg        <= '0;
            count_reg       <= '0;
        end else if (advance) begin
            hist_reg    <= hist_next;
            verdict_reg <= verdict_next;
            host_reg    <= host_next;
            if (in_last_reg) begin
                pos_reg         <= '0;
                agent_seen_reg  <= 1'b0;
                agent_start_reg <= '0;
                decided_reg     <= 1'b0;
                count_reg       <= count_new;
            end else begin
                pos_reg         <= pos_next;
                agent_seen_reg  <= agent_seen_next;
                agent_start_reg <= agent_start_next;
                decided_reg     <= decided_next;
                count_reg       <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_data_reg.capture       <= (verdict_next == VERDICT_CAPTURED);
            out_data_reg.verdict       <= verdict_next;
            out_data_reg.host_count    <= count_new;
            out_data_reg.packet_length <= 16'(pos_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ tb/http_header_capture_filter_tb.sv @@
`timescale 1ns / 1ps

module http_header_capture_filter_tb
    import hhcf_pkg::*;
;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] host;
        logic       first;
        logic       last;
        logic       tcp;
    } beat_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_index   = CFG_HOST_QUOTA;
    logic [15:0] cfg_wr_data = '0;

    beat_t       pending_bytes[$];
    result_t     expected_verdicts[$];
    logic [7:0]  pkt_body[$];
    beat_t       cur_beat;

    // shadow of the block
    logic [3:0]  quota_cfg = QUOTA_RESET;
    logic [15:0] gap_cfg   = MIN_GAP_RESET;
    logic [7:0]  recent [AGENT_LEN];
    logic [15:0] byte_pos;
    logic        agent_hit;
    logic [15:0] agent_at;
    logic        settled;
    logic [2:0]  verdict_now;
    logic [7:0]  cur_host;
    logic [COUNT_BITS-1:0] host_caps [256];

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_go   = 1'b0;
    logic rx_hold = 1'b0;

    int errors = 0;
    int cycles = 0;
    int bytes_in = 0;
    int bytes_queued = 0;
    int packets_queued = 0;
    int results_seen = 0;
    int captures_seen = 0;

    http_header_capture_filter i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        int k;
        for (k = 0; k < AGENT_LEN; k++) recent[k] = 8'h00;
        for (k = 0; k < 256; k++) host_caps[k] = '0;
        byte_pos    = '0;
        agent_hit   = 1'b0;
        agent_at    = '0;
        settled     = 1'b0;
        verdict_now = VERDICT_CAPTURED;
        cur_host    = '0;
    end

    task automatic note_mismatch(input string field, input int got_v, input int want_v);
        errors++;
        $display("[%0t] %s: got %0d, expected %0d", $time, field, got_v, want_v);
    endtask

    function automatic bit tail_spells(input bit want_agent);
        int m;
        if (want_agent) begin
            for (m = 0; m < AGENT_LEN; m++)
                if (recent[AGENT_LEN-1-m] != AGENT_PAT[m]) return 1'b0;
        end else begin
            for (m = 0; m < ACCEPT_LEN; m++)
                if (recent[ACCEPT_LEN-1-m] != ACCEPT_PAT[m]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic track_byte(input beat_t b);
        int k;
        logic [15:0] idx;
        result_t r;
        if (b.first || byte_pos == 0) begin
            for (k = 0; k < AGENT_LEN; k++) recent[k] = 8'h00;
            byte_pos  = '0;
            agent_hit = 1'b0;
            agent_at  = '0;
            cur_host  = b.host;
            if (!b.tcp) begin
                settled     = 1'b1;
                verdict_now = VERDICT_NOT_TCP;
            end else if (host_caps[cur_host] >= quota_cfg) begin
                settled     = 1'b1;
                verdict_now = VERDICT_QUOTA;
            end else begin
                settled     = 1'b0;
                verdict_now = VERDICT_NO_AGENT;
            end
        end
        for (k = AGENT_LEN - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = b.data;
        idx = byte_pos;
        if (byte_pos != POS_MAX) byte_pos++;
        if (!settled) begin
            if (!agent_hit) begin
                if (tail_spells(1'b1)) begin
                    agent_hit   = 1'b1;
                    agent_at    = (idx >= AGENT_LEN - 1) ? idx - 16'(AGENT_LEN - 1) : '0;
                    verdict_now = VERDICT_NO_ACCEPT;
                end
            end else if (tail_spells(1'b0)) begin
                settled     = 1'b1;
                verdict_now = (idx - agent_at > gap_cfg) ? VERDICT_CAPTURED : VERDICT_TOO_CLOSE;
            end
        end
        if (b.last) begin
            if (verdict_now == VERDICT_CAPTURED && host_caps[cur_host] != COUNT_MAX)
                host_caps[cur_host]++;
            r.capture       = (verdict_now == VERDICT_CAPTURED);
            r.verdict       = verdict_now;
            r.host_count    = host_caps[cur_host];
            r.packet_length = byte_pos;
            expected_verdicts.push_back(r);
            byte_pos  = '0;
            agent_hit = 1'b0;
            agent_at  = '0;
            settled   = 1'b0;
        end
    endtask

    // driver: one beat on the bus at a time
    always @(posedge aclk) begin : driver
        logic go;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_byte(cur_beat);
                bytes_in++;
            end
            if (!s_tvalid || s_tready) begin
                go = pending_bytes.size() > 0 && (tx_steady || $urandom_range(0, 99) >= 30);
                if (go) begin
                    cur_beat = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_beat.host, cur_beat.data};
                    s_tuser  <= {cur_beat.tcp, cur_beat.first};
                    s_tlast  <= cur_beat.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                results_seen++;
                if (got.capture) captures_seen++;
                if (expected_verdicts.size() == 0) begin
                    note_mismatch("result beat with no packet pending, tdata", m_tdata, -1);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.capture != want.capture)
                        note_mismatch("capture", got.capture, want.capture);
                    if (got.verdict != want.verdict)
                        note_mismatch("verdict", got.verdict, want.verdict);
                    if (got.host_count != want.host_count)
                        note_mismatch("host_count", got.host_count, want.host_count);
                    if (got.packet_length != want.packet_length)
                        note_mismatch("packet_length", got.packet_length, want.packet_length);
                end
            end
            m_tready <= !rx_hold && (rx_steady || $urandom_range(0, 99) >= 30);
        end
    end

    initial begin : rx_holdoff
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycles, expected_verdicts.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic set_reg(input logic idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == CFG_HOST_QUOTA) quota_cfg = val[3:0];
        else gap_cfg = val;
    endtask

    task automatic settle();
        while (pending_bytes.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_agent();
        int k;
        for (k = 0; k < AGENT_LEN; k++) pkt_body.push_back(AGENT_PAT[k]);
    endtask

    task automatic put_accept();
        int k;
        for (k = 0; k < ACCEPT_LEN; k++) pkt_body.push_back(ACCEPT_PAT[k]);
    endtask

    // header letters mixed in to provoke partial matches
    task automatic put_noise(input int n);
        int k;
        int pick;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) pkt_body.push_back(AGENT_PAT[$urandom_range(0, AGENT_LEN - 1)]);
            else if (pick < 4) pkt_body.push_back(ACCEPT_PAT[$urandom_range(0, ACCEPT_LEN - 1)]);
            else pkt_body.push_back(8'($urandom));
        end
    endtask

    task automatic send_packet(input logic tcp, input logic [7:0] host,
                               input bit mark_first, input bit mark_last);
        beat_t b;
        int k;
        for (k = 0; k < pkt_body.size(); k++) begin
            b.data  = pkt_body[k];
            b.first = mark_first && k == 0;
            b.last  = mark_last && k == pkt_body.size() - 1;
            b.tcp   = (k == 0) ? tcp : 1'($urandom);
            b.host  = (k == 0) ? host : 8'($urandom);
            pending_bytes.push_back(b);
        end
        bytes_queued += pkt_body.size();
        packets_queued++;
        pkt_body.delete();
    endtask

    function automatic logic [7:0] pick_host();
        logic [7:0] hosts [6] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd128, 8'd255};
        if ($urandom_range(0, 9) < 7) return hosts[$urandom_range(0, 5)];
        return 8'($urandom);
    endfunction

    // filler between the two headers; for a gap up to 300, half the time right at the gap boundary
    function automatic int pick_mid();
        int g;
        g = gap_cfg;
        if (g <= 300 && $urandom_range(0, 1) == 1) begin
            g = g - 15 + int'($urandom_range(0, 3)) - 1;
            return (g < 0) ? 0 : g;
        end
        return $urandom_range(0, (g < 60) ? g + 20 : 80);
    endfunction

    task automatic random_packet();
        int kind;
        int k;
        int cut;
        logic [7:0] host;
        logic tcp;
        host = pick_host();
        tcp  = $urandom_range(0, 99) < 85;
        if ($urandom_range(0, 24) == 0) begin
            put_noise($urandom_range(1, 4));
            put_agent();
            send_packet(tcp, host, 1'b1, 1'b0);
        end
        kind = $urandom_range(0, 9);
        put_noise($urandom_range(0, 6));
        if (kind <= 5) begin
            put_agent();
            if (kind <= 4) begin
                put_noise(pick_mid());
                put_accept();
                if ($urandom_range(0, 3) == 0) begin
                    put_noise($urandom_range(0, 5));
                    put_accept();
                end
            end
        end else if (kind == 6) begin
            cut = $urandom_range(1, AGENT_LEN - 1);
            for (k = 0; k < cut; k++) pkt_body.push_back(AGENT_PAT[k]);
            put_noise($urandom_range(0, 4));
            put_accept();
        end else if (kind == 7) begin
            put_accept();
            put_noise($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1) put_agent();
        end else if (kind == 8) begin
            put_noise($urandom_range(1, 30));
        end
        put_noise($urandom_range((kind == 9) ? 1 : 0, 4));
        send_packet(tcp, host, $urandom_range(0, 19) != 0, 1'b1);
    endtask

    task automatic random_phase(input int min_bytes, input int min_pkts);
        int start;
        int pkts;
        start = bytes_queued;
        pkts  = 0;
        while (bytes_queued - start < min_bytes || pkts < min_pkts) begin
            random_packet();
            pkts++;
        end
    endtask

    initial begin : stimulus
        int k;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        set_reg(CFG_MIN_GAP, 16'd15);
        pkt_body.push_back(8'h00);
        send_packet(1'b1, 8'h00, 1'b1, 1'b1);
        pkt_body.push_back(8'hFF);
        send_packet(1'b0, 8'hFF, 1'b1, 1'b1);
        put_agent(); put_accept();
        send_packet(1'b1, 8'd1, 1'b1, 1'b1);
        put_agent(); put_noise(1); put_accept();
        send_packet(1'b1, 8'd1, 1'b1, 1'b1);
        put_noise(2); put_agent(); put_noise(3);
        send_packet(1'b1, 8'd1, 1'b1, 1'b1);
        put_accept(); put_agent();
        send_packet(1'b1, 8'd2, 1'b1, 1'b1);
        put_agent(); put_noise(2); put_accept();
        send_packet(1'b1, 8'd2, 1'b0, 1'b1);
        put_agent(); put_noise(4);
        send_packet(1'b1, 8'd1, 1'b1, 1'b0);
        for (k = 0; k < 3; k++) begin
            put_agent(); put_noise(1); put_accept();
            send_packet(1'b1, 8'd1, 1'b1, 1'b1);
        end
        put_agent(); put_noise(1); put_accept();
        send_packet(1'b0, 8'd3, 1'b1, 1'b1);
        settle();

        set_reg(CFG_HOST_QUOTA, 16'd0);
        random_phase(40, 3);
        settle();

        // one host run up to its quota
        set_reg(CFG_HOST_QUOTA, 16'd5);
        set_reg(CFG_MIN_GAP, 16'd0);
        for (k = 0; k < 6; k++) begin
            put_agent(); put_accept();
            send_packet(1'b1, 8'd77, 1'b1, 1'b1);
        end
        settle();

        set_reg(CFG_HOST_QUOTA, 16'd2);
        set_reg(CFG_MIN_GAP, 16'd0);
        random_phase(60, 5);
        settle();

        // receiver held off while the sender keeps offering
        set_reg(CFG_HOST_QUOTA, 16'd15);
        set_reg(CFG_MIN_GAP, 16'd40);
        tx_steady = 1'b1;
        for (k = 0; k < 20; k++) begin
            pkt_body.push_back(8'($urandom));
            send_packet(1'($urandom), pick_host(), 1'b1, 1'b1);
        end
        random_phase(40, 2);
        hold_go = 1'b1;
        settle();
        tx_steady = 1'b0;

        set_reg(CFG_HOST_QUOTA, 16'd1);
        set_reg(CFG_MIN_GAP, 16'hFFFF);
        random_phase(40, 3);
        settle();

        set_reg(CFG_HOST_QUOTA, 16'(QUOTA_RESET));
        set_reg(CFG_MIN_GAP, MIN_GAP_RESET);
        random_phase(60, 2);
        settle();

        set_reg(CFG_HOST_QUOTA, 16'd7);
        set_reg(CFG_MIN_GAP, 16'd20);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_phase(40, 4);
        settle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        repeat (10) @(posedge aclk);
        if (expected_verdicts.size() != 0)
            note_mismatch("verdicts never delivered", 0, expected_verdicts.size());
        $display("%0d bytes in %0d packets sent, %0d verdicts checked, %0d captures",
                 bytes_in, packets_queued, results_seen, captures_seen);
        $display("quota 0..15, gap 0..65535, missing and early first marks, output hold-off");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
